>>> rtl/hps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hps_pkg;

    // Field widths
    localparam int FUNC_W    = 3;
    localparam int FEATURE_W = 8;
    localparam int PORT_W    = 8;
    localparam int STATUS_W  = 32;
    localparam int MASK_W    = 4;
    localparam int ATTACH_W  = 4;
    localparam int BITSEL_W  = 5;

    // Default port count
    localparam int DEF_NUM_PORTS = 4;

    // Request codes
    localparam logic [FUNC_W-1:0] FUNC_SET        = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR      = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_GET        = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_EPREAD     = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_CONFIGURED = 3'd4;

    // Status bit numbers and limits
    localparam int FEAT_LIMIT       = 32;
    localparam int CHANGE_BASE      = 16;
    localparam int BIT_CONNECTION   = 0;
    localparam int BIT_ENABLE       = 1;
    localparam int BIT_RESET        = 4;
    localparam int BIT_C_CONNECTION = 16;
    localparam int BIT_C_RESET      = 20;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_OUT  = 3'b100
    } hps_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic execute;
    } hps_cmd_t;

endpackage

`default_nettype wire

>>> rtl/hps_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module hps_ctrl
    import hps_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  wire logic     m_ready,
    output hps_cmd_t      cmd
);

    hps_state_t state_reg;
    hps_state_t state_next;

    // Sequence: take request, execute, present result
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_EXEC;
            end
            ST_EXEC: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_ready) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Drive handshakes and commands
    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = (state_reg == ST_OUT);
    assign cmd.capture = s_valid && s_ready;
    assign cmd.execute = (state_reg == ST_EXEC);

`ifndef SYNTH
    // Never take a request while a result is pending
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while result pending");

    // A captured request executes in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |=> cmd.execute)
        else $error("capture not followed by execute");

    // Execution always yields a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.execute |=> m_valid)
        else $error("execute not followed by result");

    // A delivered result frees the input side
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready) |=> s_ready)
        else $error("no return to idle after transfer");
`endif

endmodule

`default_nettype wire

>>> rtl/hps_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module hps_datapath
    import hps_pkg::*;
#(
    parameter int NUM_PORTS = DEF_NUM_PORTS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire hps_cmd_t              cmd,
    input  wire logic [FUNC_W-1:0]     s_func,
    input  wire logic [FEATURE_W-1:0]  s_feature,
    input  wire logic [PORT_W-1:0]     s_port,
    input  wire logic                  cfg_we,
    input  wire logic [ATTACH_W-1:0]   cfg_wdata,
    output logic                       m_accepted,
    output logic [STATUS_W-1:0]        m_port_status,
    output logic [MASK_W-1:0]          m_change_mask,
    output logic                       m_report_valid
);

    localparam int PIDX_W = $clog2(NUM_PORTS);
    localparam int EXT_W  = (NUM_PORTS > MASK_W) ? NUM_PORTS : MASK_W;
    localparam logic [STATUS_W-1:0] CONN_WORD =
        (STATUS_W'(1) << BIT_CONNECTION) | (STATUS_W'(1) << BIT_C_CONNECTION);

    // Captured request
    logic [FUNC_W-1:0]    func_reg;
    logic [FEATURE_W-1:0] feature_reg;
    logic [PORT_W-1:0]    port_reg;

    // Hub state
    logic [STATUS_W-1:0]  words_reg [NUM_PORTS];
    logic [STATUS_W-1:0]  words_next [NUM_PORTS];
    logic [NUM_PORTS-1:0] change_reg;
    logic [NUM_PORTS-1:0] change_next;
    logic [ATTACH_W-1:0]  attached_reg;

    // Result registers
    logic                 acc_reg;
    logic                 acc_next;
    logic [STATUS_W-1:0]  status_reg;
    logic [STATUS_W-1:0]  status_next;
    logic [MASK_W-1:0]    mask_reg;
    logic                 report_reg;

    // Working signals
    logic [PIDX_W-1:0]    pidx;
    logic [BITSEL_W-1:0]  bsel;
    logic                 port_ok;
    logic                 feat_ok;
    logic                 feat_low;
    logic [STATUS_W-1:0]  cur_word;
    logic [STATUS_W-1:0]  bit_vec;
    logic [STATUS_W-1:0]  upd_word;
    logic                 mark;
    logic [EXT_W-1:0]     attached_ext;
    logic [EXT_W-1:0]     change_ext;

    assign pidx         = port_reg[PIDX_W-1:0];
    assign bsel         = feature_reg[BITSEL_W-1:0];
    assign port_ok      = (port_reg < PORT_W'(NUM_PORTS));
    assign feat_ok      = (feature_reg < FEATURE_W'(FEAT_LIMIT));
    assign feat_low     = (feature_reg < FEATURE_W'(CHANGE_BASE));
    assign cur_word     = words_reg[pidx];
    assign bit_vec      = STATUS_W'(1) << bsel;
    assign attached_ext = EXT_W'(attached_reg);
    assign change_ext   = EXT_W'(change_next);

    // Hold the request on transfer
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            func_reg    <= s_func;
            feature_reg <= s_feature;
            port_reg    <= s_port;
        end
    end

    // Attached-port register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attached_reg <= '0;
        end else if (cfg_we) begin
            attached_reg <= cfg_wdata;
        end
    end

    // Read-modify-write of the addressed (or attached) port words and the bitmap
    always_comb begin
        words_next  = words_reg;
        change_next = change_reg;
        upd_word    = cur_word;
        mark        = 1'b0;
        acc_next    = 1'b0;
        status_next = '0;
        unique case (func_reg)
            FUNC_SET: begin
                if (feat_ok && port_ok) begin
                    acc_next = 1'b1;
                    if ((cur_word & bit_vec) == '0) begin
                        upd_word = cur_word | bit_vec;
                        mark     = feat_low;
                        // Port reset completes at once: enable plus reset change
                        if (feature_reg == FEATURE_W'(BIT_RESET)) begin
                            upd_word = (upd_word & ~(STATUS_W'(1) << BIT_RESET))
                                     | (STATUS_W'(1) << BIT_C_RESET)
                                     | (STATUS_W'(1) << BIT_ENABLE);
                        end
                        words_next[pidx] = upd_word;
                    end
                end
            end
            FUNC_CLEAR: begin
                if (feat_ok && port_ok) begin
                    acc_next = 1'b1;
                    if ((cur_word & bit_vec) != '0) begin
                        upd_word         = cur_word & ~bit_vec;
                        mark             = feat_low;
                        words_next[pidx] = upd_word;
                    end
                end
            end
            FUNC_GET: begin
                if (port_ok) begin
                    acc_next    = 1'b1;
                    status_next = cur_word;
                end
            end
            FUNC_EPREAD: begin
                acc_next    = 1'b1;
                change_next = '0;
            end
            FUNC_CONFIGURED: begin
                acc_next = 1'b1;
                for (int p = 1; p < NUM_PORTS; p++) begin
                    if (p < ATTACH_W && attached_ext[p]) begin
                        words_next[p] = CONN_WORD;
                    end
                end
            end
            default: begin
                acc_next = 1'b0;
            end
        endcase
        if (mark) begin
            change_next = change_reg | (NUM_PORTS'(1) << pidx);
        end
    end

    // Commit state on execute
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_PORTS; i++) begin
                words_reg[i] <= '0;
            end
            change_reg <= '0;
        end else if (cmd.execute) begin
            words_reg  <= words_next;
            change_reg <= change_next;
        end
    end

    // Load the result registers
    always_ff @(posedge aclk) begin
        if (cmd.execute) begin
            acc_reg    <= acc_next;
            status_reg <= status_next;
            mask_reg   <= change_ext[MASK_W-1:0];
            report_reg <= (change_next != change_reg) && (func_reg != FUNC_EPREAD);
        end
    end

    assign m_accepted     = acc_reg;
    assign m_port_status  = status_reg;
    assign m_change_mask  = mask_reg;
    assign m_report_valid = report_reg;

endmodule

`default_nettype wire

>>> rtl/hub_port_status_engine.sv
// Hub port status engine.
// Input channel (s_valid/s_ready, s_func, s_feature, s_port) carries one hub
// class request or event per transfer: set feature, clear feature, get port
// status, status endpoint read, configured. The result channel
// (m_valid/m_ready) returns exactly one result per request: accepted flag,
// port status word (get status only), the change bitmap of ports 0 to 3 after
// the request, and a report flag raised when set or clear changed the bitmap.
// cfg_we/cfg_wdata write the attached-ports register; write it only while idle.
// A taken request passes through the execute state, then the present state,
// where its result is valid. The block handles one request at a time: idle,
// execute, present, so a new request is not taken until the previous result
// has transferred. While the receiver stalls, the result holds and s_ready
// stays low.
// Synchronous reset (aresetn low) clears all port words, the change bitmap
// and the attached-ports register, and returns the controller to idle.
`timescale 1ns / 1ps
`default_nettype none

module hub_port_status_engine
    import hps_pkg::*;
#(
    parameter int NUM_PORTS = DEF_NUM_PORTS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [FUNC_W-1:0]     s_func,
    input  wire logic [FEATURE_W-1:0]  s_feature,
    input  wire logic [PORT_W-1:0]     s_port,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_accepted,
    output logic [STATUS_W-1:0]        m_port_status,
    output logic [MASK_W-1:0]          m_change_mask,
    output logic                       m_report_valid,
    input  wire logic                  cfg_we,
    input  wire logic [ATTACH_W-1:0]   cfg_wdata
);

    hps_cmd_t cmd;

    // Sequencing
    hps_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // Port state and result
    hps_datapath #(
        .NUM_PORTS (NUM_PORTS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .s_func         (s_func),
        .s_feature      (s_feature),
        .s_port         (s_port),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .m_accepted     (m_accepted),
        .m_port_status  (m_port_status),
        .m_change_mask  (m_change_mask),
        .m_report_valid (m_report_valid)
    );

endmodule

`default_nettype wire
